### rtl/core/mru_pkg.sv
// Shared types and constants of the mixed-radix unit split block.
package mru_pkg;

	localparam int DATA_W    = 64;
	localparam int RADIX_W   = 16;
	localparam int NUM_RADIX = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CNT_W     = 3;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_COUNT  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_FIRST = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIX_LAST  = 4'd7;

	localparam logic [CNT_W-1:0] UNIT_COUNT_RESET = 3'd7;

	// Radix table after reset, unit 0 in the lowest slot
	localparam logic [NUM_RADIX-1:0][RADIX_W-1:0] RADIX_RESET = {
		16'd365, 16'd12, 16'd30, 16'd24, 16'd60, 16'd60, 16'd1000
	};

	// Sign codes of the difference
	localparam logic signed [1:0] SIGN_POS  = 2'sb01;
	localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
	localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

	typedef struct packed {
		logic [CNT_W-1:0]                     unit_count;
		logic [NUM_RADIX-1:0][RADIX_W-1:0]    radix;
	} cfg_regs_t;

	typedef struct packed {
		logic               start;
		logic [DATA_W-1:0]  dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DATA_W-1:0]  quotient;
		logic [RADIX_W-1:0] remainder;
	} div_stat_t;

endpackage

### rtl/core/mru_if.sv
// Channel interfaces of the mixed-radix unit split block.
interface mru_in_if import mru_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [DATA_W-1:0] value_a;
	logic [DATA_W-1:0] value_b;
	logic [2:0]        max_extra_units;

	modport source (output valid, op, value_a, value_b, max_extra_units, input ready);
	modport sink   (input valid, op, value_a, value_b, max_extra_units, output ready);
endinterface

interface mru_out_if import mru_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [2:0]         unit_index;
	logic [DATA_W-1:0]  digit_value;
	logic [CNT_W-1:0]   units_used;
	logic signed [1:0]  sign;
	logic               last;

	modport source (output valid, unit_index, digit_value, units_used, sign, last, input ready);
	modport sink   (input valid, unit_index, digit_value, units_used, sign, last, output ready);
endinterface

interface mru_cfg_if import mru_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RADIX_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mru_regs.sv
// Configuration register file: unit count and radix table.
module mru_regs import mru_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mru_cfg_if.sink   cfg,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Write one register per request, drop indexes past the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.unit_count <= UNIT_COUNT_RESET;
			regs_q.radix      <= RADIX_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_UNIT_COUNT) begin
				regs_q.unit_count <= cfg.data[CNT_W-1:0];
			end else if (cfg.index >= REG_RADIX_FIRST && cfg.index <= REG_RADIX_LAST) begin
				regs_q.radix[3'(cfg.index - REG_RADIX_FIRST)] <= cfg.data;
			end
		end
	end

endmodule

### rtl/core/mru_div.sv
// Bit-serial restoring divider: 64-bit dividend by a 16-bit radix.
module mru_div import mru_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	localparam int STEP_W = $clog2(DATA_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [DATA_W-1:0]   quo_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  den_q;

	logic [RADIX_W:0]    trial;
	logic [RADIX_W:0]    diff;
	logic                fits;

	// One quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift dividend into quotient, keep partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], fits};
			rem_q <= fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign stat.busy      = busy_q;
	assign stat.done      = done_q;
	assign stat.quotient  = quo_q;
	assign stat.remainder = rem_q;

	// A new division only starts on an idle divider
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	// Done follows the last step
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without a running division");

	// Remainder stays below the divisor once finished
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < den_q)
		else $error("remainder not below divisor");

endmodule

### rtl/core/mixed_radix_unit_split_top.sv
// Top level of the mixed-radix unit split block: sequencer, output register and units.
//
// An accepted request is reduced to one value (value_a, or |value_a - value_b| with its
// sign) and divided serially by the configured radixes in one shared bit-serial divider.
// Each division loads its operands and then works out the 64 quotient bits, and a zero
// value skips the divider and goes straight to emission. Results leave highest unit first
// through an output register, and a stalled output stretches the emission phase. The
// input is ready only while the sequencer is idle. Configuration writes are taken at
// any time and must only be issued while the block is idle.
module mixed_radix_unit_split_top import mru_pkg::*; #(
	parameter int MAX_UNITS = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	mru_in_if.sink     in_ch,
	mru_out_if.source  out_ch,
	mru_cfg_if.sink    cfg
);

	localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_UNITS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t             state_q;
	cfg_regs_t          regs;
	div_req_t           div_req;
	div_stat_t          div_stat;

	logic               op_q;
	logic [DATA_W-1:0]  a_q;
	logic [DATA_W-1:0]  b_q;
	logic [3:0]         lim_q;
	logic signed [1:0]  sign_q;
	logic [DATA_W-1:0]  cur_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [IW-1:0]      k_q;
	logic [DATA_W-1:0]  digits_q [MAX_UNITS];

	logic               out_valid_q;
	logic [2:0]         out_unit_q;
	logic [DATA_W-1:0]  out_digit_q;
	logic [CNT_W-1:0]   out_used_q;
	logic signed [1:0]  out_sign_q;
	logic               out_last_q;

	logic [DATA_W:0]    diff_ab;
	logic [DATA_W-1:0]  diff_ba;
	logic [DATA_W-1:0]  val;
	logic signed [1:0]  sign_d;
	logic [CNT_W-1:0]   n_eff;
	logic [CNT_W-1:0]   idx_nx;
	logic               stop;
	logic               out_free;
	logic [2:0]         rad_sel;
	logic [RADIX_W-1:0] rad_raw;

	mru_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mru_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// Reduce the request to one value and its sign
	always_comb begin
		diff_ab = {1'b0, a_q} - {1'b0, b_q};
		diff_ba = b_q - a_q;
		if (!op_q) begin
			val    = a_q;
			sign_d = SIGN_ZERO;
		end else if (diff_ab[DATA_W]) begin
			val    = diff_ba;
			sign_d = SIGN_NEG;
		end else begin
			val    = diff_ab[DATA_W-1:0];
			sign_d = (diff_ab[DATA_W-1:0] == '0) ? SIGN_ZERO : SIGN_POS;
		end
	end

	// Clamp the unit count and decide where the split ends
	always_comb begin
		if (regs.unit_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (regs.unit_count > MAX_CNT) begin
			n_eff = MAX_CNT;
		end else begin
			n_eff = regs.unit_count;
		end
		idx_nx = idx_q + CNT_W'(1);
		stop   = (idx_nx >= n_eff) || (div_stat.quotient == '0) || ({1'b0, idx_nx} >= lim_q);
	end

	// Launch divisions: first from the prepared value, then from each quotient
	always_comb begin
		rad_sel          = (state_q == ST_PREP) ? 3'd0 : idx_nx;
		rad_raw          = regs.radix[rad_sel];
		div_req.divisor  = (rad_raw == '0) ? RADIX_W'(1) : rad_raw;
		div_req.dividend = (state_q == ST_PREP) ? val : div_stat.quotient;
		div_req.start    = ((state_q == ST_PREP) && (val != '0)) ||
		                   ((state_q == ST_DIV) && div_stat.done && !stop);
	end

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= (val == '0) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done && stop) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && k_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and digit collection
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					op_q  <= in_ch.op;
					a_q   <= in_ch.value_a;
					b_q   <= in_ch.value_b;
					lim_q <= {1'b0, in_ch.max_extra_units} + 4'd1;
				end
			end
			ST_PREP: begin
				sign_q <= sign_d;
				cur_q  <= val;
				idx_q  <= '0;
				if (val == '0) begin
					digits_q[0] <= '0;
					count_q     <= '0;
					k_q         <= '0;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					if (stop) begin
						// last unit keeps the whole dividend: folded leftover
						digits_q[idx_q[IW-1:0]] <= cur_q;
						count_q                 <= idx_nx;
						k_q                     <= idx_q[IW-1:0];
					end else begin
						digits_q[idx_q[IW-1:0]] <= {{(DATA_W-RADIX_W){1'b0}}, div_stat.remainder};
						cur_q                   <= div_stat.quotient;
						idx_q                   <= idx_nx;
					end
				end
			end
			ST_EMIT: begin
				if (out_free && k_q != '0) begin
					k_q <= k_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, highest unit first
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_unit_q  <= 3'(k_q);
			out_digit_q <= digits_q[k_q];
			out_used_q  <= count_q;
			out_sign_q  <= sign_q;
			out_last_q  <= (k_q == '0);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.unit_index  = out_unit_q;
	assign out_ch.digit_value = out_digit_q;
	assign out_ch.units_used  = out_used_q;
	assign out_ch.sign        = out_sign_q;
	assign out_ch.last        = out_last_q;

	// Only the unit 0 result closes a run
	a_last_unit0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_unit_q == 3'd0)))
		else $error("last flag not on unit 0");

	// A zero value gives a zero digit
	a_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_used_q == '0) |-> (out_digit_q == '0 && out_last_q))
		else $error("zero value run malformed");

	// A result's unit lies below the number of units used
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_used_q != '0) |-> (out_unit_q < out_used_q))
		else $error("unit index beyond units used");

	// No division runs while results are sent
	a_emit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !div_stat.busy)
		else $error("divider busy during emission");

endmodule

### dv/mru_tb_pkg.sv
`timescale 1ns / 100ps
// Operation codes and the digit record shared by the split testbench files.
package mru_tb_pkg;
	import mru_pkg::*;

	localparam logic OP_SPLIT = 1'b0;
	localparam logic OP_DIFF  = 1'b1;

	// One emitted digit as seen on the result channel
	typedef struct packed {
		logic [2:0]        unit_index;
		logic [DATA_W-1:0] digit_value;
		logic [CNT_W-1:0]  units_used;
		logic signed [1:0] sign;
		logic              last;
	} digit_rec_t;

endpackage

### dv/mru_split_checker.sv
`timescale 1ns / 100ps
// Checker of the mixed-radix split: tracks the radix table, predicts digits, compares results.
module mru_split_checker import mru_pkg::*; import mru_tb_pkg::*; #(
	parameter int MAX_UNITS = 7
) (
	input  logic clk,
	input  logic arst_n,
	mru_in_if    in_mon,
	mru_out_if   out_mon,
	mru_cfg_if   cfg_mon,
	output int   fail_count,
	output int   outstanding,
	output int   requests_seen,
	output int   results_seen
);

	logic [CNT_W-1:0]   unit_cnt;
	logic [RADIX_W-1:0] radix [NUM_RADIX];
	digit_rec_t         digits_due[$];
	digit_rec_t         got_rec;
	digit_rec_t         want_rec;
	int                 errors;

	assign fail_count = errors;

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: digit mismatch: %s", $time, what);
	endtask

	// A zero radix divides as one
	function automatic logic [DATA_W-1:0] eff_radix(input int i);
		return (radix[i] == '0) ? DATA_W'(1) : DATA_W'(radix[i]);
	endfunction

	// Split one request into digits, highest unit first, and queue them
	function automatic void predict_split(input logic op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [2:0] max_extra);
		logic [DATA_W-1:0] mag;
		logic [DATA_W-1:0] cur;
		logic [DATA_W-1:0] div;
		logic [DATA_W-1:0] digit [NUM_RADIX];
		logic signed [1:0] sgn;
		int                span;
		int                cap;
		int                used;
		digit_rec_t        rec;
		mag = a;
		sgn = SIGN_ZERO;
		if (op == OP_DIFF) begin
			if (a > b) begin
				sgn = SIGN_POS;
				mag = a - b;
			end else if (a == b) begin
				mag = '0;
			end else begin
				sgn = SIGN_NEG;
				mag = b - a;
			end
		end
		span = (unit_cnt == '0) ? 1 : int'(unit_cnt);
		if (span > MAX_UNITS)
			span = MAX_UNITS;
		cap = int'(max_extra) + 1;
		if (mag == '0) begin
			rec = '{unit_index: '0, digit_value: '0, units_used: '0, sign: sgn, last: 1'b1};
			digits_due.push_back(rec);
			return;
		end
		cur  = mag;
		used = 0;
		do begin
			div = eff_radix(used);
			digit[used] = cur % div;
			cur = cur / div;
			used++;
		end while (used < span && cur != '0 && used < cap);
		// fold any leftover back into the highest unit
		if (cur != '0)
			digit[used-1] = digit[used-1] + cur * eff_radix(used - 1);
		for (int k = used - 1; k >= 0; k--) begin
			rec.unit_index  = 3'(k);
			rec.digit_value = digit[k];
			rec.units_used  = CNT_W'(used);
			rec.sign        = sgn;
			rec.last        = (k == 0);
			digits_due.push_back(rec);
		end
	endfunction

	// Compare a result with the oldest expected digit
	task automatic compare_digit(input digit_rec_t got, input digit_rec_t want);
		if (got.unit_index !== want.unit_index)
			report_mismatch($sformatf("unit_index %0d, expected %0d",
				got.unit_index, want.unit_index));
		if (got.digit_value !== want.digit_value)
			report_mismatch($sformatf("unit %0d digit_value %0d, expected %0d",
				want.unit_index, got.digit_value, want.digit_value));
		if (got.units_used !== want.units_used)
			report_mismatch($sformatf("unit %0d units_used %0d, expected %0d",
				want.unit_index, got.units_used, want.units_used));
		if (got.sign !== want.sign)
			report_mismatch($sformatf("unit %0d sign %0d, expected %0d",
				want.unit_index, got.sign, want.sign));
		if (got.last !== want.last)
			report_mismatch($sformatf("unit %0d last %0b, expected %0b",
				want.unit_index, got.last, want.last));
	endtask

	// Watch all three channels on each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_cnt = UNIT_COUNT_RESET;
			for (int i = 0; i < NUM_RADIX; i++)
				radix[i] = RADIX_RESET[i];
			digits_due.delete();
			outstanding <= 0;
		end else begin
			// drain first so a new request never matches an old result
			if (out_mon.valid && out_mon.ready) begin
				results_seen++;
				got_rec = '{unit_index: out_mon.unit_index, digit_value: out_mon.digit_value,
					units_used: out_mon.units_used, sign: out_mon.sign, last: out_mon.last};
				if (digits_due.size() == 0) begin
					report_mismatch($sformatf("unit %0d result with nothing expected",
						got_rec.unit_index));
				end else begin
					want_rec = digits_due.pop_front();
					compare_digit(got_rec, want_rec);
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == REG_UNIT_COUNT)
					unit_cnt = cfg_mon.data[CNT_W-1:0];
				else if (cfg_mon.index >= REG_RADIX_FIRST && cfg_mon.index <= REG_RADIX_LAST)
					radix[cfg_mon.index - REG_RADIX_FIRST] = cfg_mon.data;
			end
			if (in_mon.valid && in_mon.ready) begin
				requests_seen++;
				predict_split(in_mon.op, in_mon.value_a, in_mon.value_b, in_mon.max_extra_units);
			end
			outstanding <= digits_due.size();
		end
	end

endmodule

### dv/tb_mixed_radix_unit_split_top.sv
`timescale 1ns / 100ps
// Testbench top of the mixed-radix split: clock, reset, request and register stimulus, verdict.
module tb_mixed_radix_unit_split_top;
	import mru_pkg::*;
	import mru_tb_pkg::*;

	localparam int                CYCLE_LIMIT      = 1_000_000;
	localparam int                LONG_HOLD_CYCLES = 1500;
	localparam int                PHASE_ITEMS      = 27;
	localparam int                NUM_PHASES       = 7;
	localparam logic [DATA_W-1:0] ALL_ONES         = '1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   requests_seen;
	int   results_seen;
	int   cycle_cnt;
	int   diff_ops;
	int   reg_writes;
	int   tables_used;
	bit   idle_on;
	bit   hold_req;

	mru_in_if  in_ch();
	mru_out_if out_ch();
	mru_cfg_if cfg();

	mixed_radix_unit_split_top #(.MAX_UNITS(7)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	mru_split_checker #(.MAX_UNITS(7)) chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.cfg_mon       (cfg),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.requests_seen (requests_seen),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive result ready: random stall bursts, one long hold-off on request
	initial begin : result_ready_gen
		bit hold_served;
		hold_served = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				out_ch.ready <= 1'b0;
				for (int n = 0; n < LONG_HOLD_CYCLES; n++)
					@(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat (idle_on ? $urandom_range(1, 13) : 1) @(posedge clk);
			end
		end
	end

	// Offer one request and hold it until taken
	task automatic push_request(input logic op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [2:0] max_extra);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.op              <= op;
		in_ch.value_a         <= a;
		in_ch.value_b         <= b;
		in_ch.max_extra_units <= max_extra;
		if (op == OP_DIFF)
			diff_ops++;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Write one register, then leave the port quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RADIX_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	// Drop the request line and wait until every digit is back
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_table(input logic [RADIX_W-1:0] uc_word,
			input logic [RADIX_W-1:0] tbl [NUM_RADIX]);
		write_reg(REG_UNIT_COUNT, uc_word);
		for (int i = 0; i < NUM_RADIX; i++)
			write_reg(REG_RADIX_FIRST + CFG_IDX_W'(i), tbl[i]);
		tables_used++;
	endtask

	// Mix of tiny, mid, near-max and full-width values
	function automatic logic [DATA_W-1:0] pick_value();
		logic [DATA_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: v = DATA_W'($urandom_range(0, 3));
			1: v = DATA_W'($urandom_range(0, 100000));
			2: v = v >> $urandom_range(1, 63);
			3: v = ALL_ONES - DATA_W'($urandom_range(0, 15));
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_random();
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              op;
		op = $urandom_range(0, 1) ? OP_DIFF : OP_SPLIT;
		a  = pick_value();
		case ($urandom_range(0, 3))
			0: b = a;
			1: b = a + DATA_W'($urandom_range(0, 5000));
			2: b = a - DATA_W'($urandom_range(0, 5000));
			default: b = pick_value();
		endcase
		push_request(op, a, b, 3'($urandom_range(0, 7)));
	endtask

	initial begin : stimulus
		logic [RADIX_W-1:0] tbl [NUM_RADIX];
		logic [RADIX_W-1:0] uc_word;
		logic [DATA_W-1:0]  a;
		idle_on  = 1'b1;
		hold_req = 1'b0;
		arst_n                <= 1'b0;
		in_ch.valid           <= 1'b0;
		in_ch.op              <= OP_SPLIT;
		in_ch.value_a         <= '0;
		in_ch.value_b         <= '0;
		in_ch.max_extra_units <= '0;
		cfg.valid             <= 1'b0;
		cfg.index             <= REG_UNIT_COUNT;
		cfg.data              <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset table: zero, equal, signs, fold, limits
		push_request(OP_SPLIT, '0, ALL_ONES, 3'd7);
		a = pick_value();
		push_request(OP_DIFF, a, a, 3'd7);
		push_request(OP_DIFF, 64'd5, 64'd9, 3'd7);
		push_request(OP_DIFF, ALL_ONES, '0, 3'd7);
		push_request(OP_DIFF, '0, ALL_ONES, 3'd7);
		push_request(OP_SPLIT, ALL_ONES, '0, 3'd7);
		push_request(OP_SPLIT, ALL_ONES, '0, 3'd0);
		push_request(OP_SPLIT, 64'd999, '0, 3'd7);
		push_request(OP_SPLIT, 64'd1000, '0, 3'd7);
		push_request(OP_SPLIT, 64'd123456789, '0, 3'd2);
		push_request(OP_DIFF, 64'd86400000, 64'd3, 3'd4);
		push_request(OP_SPLIT, 64'd31104000000, '0, 3'd7);
		settle();

		// unit count zero, zero radix, write to an unused index
		write_reg(REG_RADIX_LAST + CFG_IDX_W'($urandom_range(1, 8)), 16'hBEEF);
		write_reg(REG_UNIT_COUNT, 16'hFFF8);
		write_reg(REG_RADIX_FIRST, 16'd0);
		tables_used++;
		push_request(OP_SPLIT, 64'd12345, '0, 3'd7);
		push_request(OP_DIFF, 64'd3, ALL_ONES, 3'd5);
		push_request(OP_SPLIT, '0, '0, 3'd0);
		settle();

		// short table with the widest and narrowest radixes
		write_reg(REG_UNIT_COUNT, 16'd3);
		write_reg(REG_RADIX_FIRST, 16'hFFFF);
		write_reg(REG_RADIX_FIRST + 4'd1, 16'd1);
		write_reg(REG_RADIX_FIRST + 4'd2, 16'd0);
		tables_used++;
		push_request(OP_SPLIT, ALL_ONES, '0, 3'd7);
		push_request(OP_SPLIT, 64'd327678, '0, 3'd7);
		push_request(OP_DIFF, 64'd1, 64'd2, 3'd7);
		push_request(OP_SPLIT, 64'd65535, '0, 3'd1);
		settle();

		// random phases, each on its own radix table
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int i = 0; i < NUM_RADIX; i++) begin
				case (ph)
					0: tbl[i] = RADIX_RESET[i];
					1: tbl[i] = 16'hFFFF;
					2: tbl[i] = 16'd1;
					3: tbl[i] = RADIX_W'($urandom_range(0, 3));
					default: tbl[i] = $urandom_range(0, 1) ?
						RADIX_W'($urandom_range(2, 20)) : RADIX_W'($urandom);
				endcase
			end
			case (ph)
				0: uc_word = RADIX_W'(UNIT_COUNT_RESET);
				1: uc_word = 16'hFFFF;
				2: uc_word = 16'd7;
				3: uc_word = {13'($urandom), 3'd0};
				default: uc_word = RADIX_W'($urandom);
			endcase
			load_table(uc_word, tbl);
			idle_on = (ph != 2) && (ph != NUM_PHASES - 1);
			if (ph == 1)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) push_random();
			settle();
		end

		repeat (30) @(posedge clk);
		$display("Split %0d requests (%0d as differences) into %0d digit results,",
			requests_seen, diff_ops, results_seen);
		$display("over %0d radix tables, %0d register writes and one long result stall.",
			tables_used, reg_writes);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
